FILE: src/kts_pkg.sv
// Package for the kernel thread scheduler: thread states, result codes,
// request codes and controller states. No dependencies.
package kts_pkg;

  typedef enum logic [2:0] {
    ST_DEAD  = 3'd0,
    ST_READY = 3'd1,
    ST_RUN   = 3'd2,
    ST_TIMED = 3'd3,
    ST_SEMA  = 3'd4,
    ST_SLEEP = 3'd5
  } tstate_t;

  typedef enum logic [1:0] {
    RC_DONE     = 2'd0,
    RC_BLOCKED  = 2'd1,
    RC_NOTFOUND = 2'd2,
    RC_DEADLOCK = 2'd3
  } rc_t;

  localparam logic [3:0] F_CREATE = 4'd0;
  localparam logic [3:0] F_START  = 4'd1;
  localparam logic [3:0] F_YIELD  = 4'd2;
  localparam logic [3:0] F_EXIT   = 4'd3;
  localparam logic [3:0] F_SLEEP  = 4'd4;
  localparam logic [3:0] F_WAKEUP = 4'd5;
  localparam logic [3:0] F_CSEMA  = 4'd6;
  localparam logic [3:0] F_WAIT   = 4'd7;
  localparam logic [3:0] F_SIGNAL = 4'd8;

  localparam logic [31:0] DELAY_MAX = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_IDLE,     // waiting for a request
    S_EXEC,     // request work
    S_SIGNAL,   // scan of waiters on a signal
    S_YPREP,    // caller update for a yield
    S_RRSCAN,   // round robin search for a ready thread
    S_MINSCAN,  // least delay search
    S_ADVSCAN,  // advance timers
    S_FINISH,   // commit dispatch
    S_OUT       // result held for the consumer
  } ctl_state_t;

  typedef struct packed {
    logic load;      // capture request
    logic exec;      // run the request work
    logic sig_step;  // one signal scan step
    logic yprep;     // caller update
    logic rr_step;
    logic min_step;
    logic adv_step;
    logic finish;
    logic scan_clr;  // clear scan counter
  } cmd_t;

  typedef struct packed {
    logic go_signal;  // exec found a signal needing a scan
    logic go_yield;   // exec requires a yield
    logic scan_last;  // counter on its last element
    logic rr_hit;     // ready thread found
    logic any_timed;
  } sts_t;

endpackage

FILE: src/kts_datapath.sv
// Datapath of the kernel thread scheduler: thread and semaphore tables,
// scan counter and result registers. Uses kts_pkg.
module kts_datapath #(
  parameter int THREADS = 16,
  parameter int SEMAPHORES = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  kts_pkg::cmd_t   cmd,
  output kts_pkg::sts_t   sts,
  input  logic [3:0]      func,
  input  logic [7:0]      object_id,
  input  logic [15:0]     amount,
  input  logic [15:0]     limit,
  input  logic [31:0]     wait_ticks,
  output logic [1:0]      result_code,
  output logic [4:0]      created_id,
  output logic            switched,
  output logic            running_valid,
  output logic [3:0]      running_index
);

  localparam int TW = $clog2(THREADS);
  localparam int SW = (SEMAPHORES > 1) ? $clog2(SEMAPHORES) : 1;
  localparam int TCW = $clog2(THREADS + 1);
  localparam int SCW = $clog2(SEMAPHORES + 1);

  kts_pkg::tstate_t  tstate [THREADS];
  logic [31:0]       tdelay [THREADS];
  logic [7:0]        ttarget [THREADS];
  logic [7:0]        credit [THREADS];
  logic [15:0]       slevel [SEMAPHORES];
  logic [15:0]       sceil [SEMAPHORES];
  logic [TCW-1:0]    tcount;
  logic [SCW-1:0]    scount;
  logic              cur_valid;
  logic [TW-1:0]     cur_index;

  // captured request
  logic [3:0]  r_func;
  logic [7:0]  r_id;
  logic [15:0] r_amount;
  logic [15:0] r_limit;
  logic [31:0] r_ticks;
  logic [31:0] y_ticks;
  logic        old_valid;
  logic [TW-1:0] old_index;
  kts_pkg::rc_t rc;
  logic [4:0]  made;
  logic        rc_block;  // map done to blocked after yield

  logic [TW-1:0] scan;
  logic [TW-1:0] rr_idx;
  logic [16:0]   lv;
  logic [31:0]   least;
  logic          any_timed;
  logic          next_found;
  logic [TW-1:0] disp_idx;

  logic          tfound, sfound;
  logic [TW-1:0] ti;
  logic [SW-1:0] si;
  logic [TCW-1:0] last_t;
  logic [16:0]   lv_sum;

  assign tfound = (r_id != 8'd0) && ({1'b0, r_id} <= 9'(tcount));
  assign sfound = (r_id != 8'd0) && ({1'b0, r_id} <= 9'(scount));
  assign ti = TW'(r_id - 8'd1);
  assign si = SW'(r_id - 8'd1);
  assign last_t = tcount - TCW'(1);
  assign lv_sum = {1'b0, slevel[si]} + {1'b0, r_amount};

  // round robin candidate: (cur + 1 + scan) mod n
  always_comb begin
    logic [TCW:0] sum;
    sum = TCW'(old_index) + TCW'(scan) + (TCW+1)'(1);
    if (sum >= (TCW+1)'(tcount)) sum = sum - (TCW+1)'(tcount);
    rr_idx = TW'(sum);
  end

  assign sts.scan_last = ({1'b0, scan} == (TW+1)'(last_t));
  assign sts.rr_hit    = (tstate[rr_idx] == kts_pkg::ST_READY);
  assign sts.any_timed = any_timed;

  // exec decisions
  logic go_yield_c, go_signal_c;
  always_comb begin
    go_yield_c = 1'b0;
    go_signal_c = 1'b0;
    case (r_func)
      kts_pkg::F_YIELD: go_yield_c = cur_valid && tcount != '0
                                   && TCW'(cur_index) < tcount;
      kts_pkg::F_EXIT:  go_yield_c = cur_valid;
      kts_pkg::F_SLEEP: go_yield_c = cur_valid && credit[cur_index] == 8'd0;
      kts_pkg::F_WAIT:  go_yield_c = sfound && slevel[si] < r_amount && cur_valid;
      kts_pkg::F_SIGNAL: go_signal_c = sfound && tcount != '0;
      default: ;
    endcase
  end
  assign sts.go_yield = go_yield_c;
  assign sts.go_signal = go_signal_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < THREADS; i++) begin
        tstate[i]  <= kts_pkg::ST_DEAD;
        tdelay[i]  <= '0;
        ttarget[i] <= '0;
        credit[i]  <= '0;
      end
      tcount <= '0;
      scount <= '0;
      cur_valid <= 1'b0;
      cur_index <= '0;
      scan <= '0;
    end else begin
      if (cmd.scan_clr) scan <= '0;
      else if (cmd.sig_step || cmd.rr_step || cmd.min_step || cmd.adv_step)
        scan <= scan + TW'(1);

      if (cmd.exec) begin
        case (r_func)
          kts_pkg::F_CREATE: if (tcount < TCW'(THREADS)) begin
            tstate[TW'(tcount)]  <= kts_pkg::ST_READY;
            tdelay[TW'(tcount)]  <= '0;
            ttarget[TW'(tcount)] <= '0;
            tcount <= tcount + TCW'(1);
          end
          kts_pkg::F_START: if (tfound && tstate[ti] == kts_pkg::ST_READY
                                && !cur_valid) begin
            cur_valid <= 1'b1;
            cur_index <= ti;
            tstate[ti] <= kts_pkg::ST_RUN;
          end
          kts_pkg::F_EXIT: if (cur_valid) tstate[cur_index] <= kts_pkg::ST_DEAD;
          kts_pkg::F_SLEEP: if (cur_valid) begin
            if (credit[cur_index] != 8'd0)
              credit[cur_index] <= credit[cur_index] - 8'd1;
            else tstate[cur_index] <= kts_pkg::ST_SLEEP;
          end
          kts_pkg::F_WAKEUP: if (tfound) begin
            if (tstate[ti] == kts_pkg::ST_SLEEP) tstate[ti] <= kts_pkg::ST_READY;
            else if (credit[ti] != 8'd255) credit[ti] <= credit[ti] + 8'd1;
          end
          kts_pkg::F_CSEMA: if (scount < SCW'(SEMAPHORES)) scount <= scount + SCW'(1);
          kts_pkg::F_WAIT: if (go_yield_c) begin
            tstate[cur_index]  <= kts_pkg::ST_SEMA;
            ttarget[cur_index] <= r_id;
          end
          default: ;
        endcase
      end

      if (cmd.sig_step && tstate[scan] == kts_pkg::ST_SEMA
          && ttarget[scan] == r_id && lv != '0) begin
        tstate[scan]  <= kts_pkg::ST_READY;
        ttarget[scan] <= '0;
      end

      if (cmd.yprep) begin
        tdelay[cur_index] <= y_ticks;
        if (y_ticks != '0) tstate[cur_index] <= kts_pkg::ST_TIMED;
        else if (tstate[cur_index] == kts_pkg::ST_RUN)
          tstate[cur_index] <= kts_pkg::ST_READY;
      end

      if (cmd.adv_step && tstate[scan] == kts_pkg::ST_TIMED) begin
        tdelay[scan] <= tdelay[scan] - least;
        if (tdelay[scan] == least) tstate[scan] <= kts_pkg::ST_READY;
      end

      if (cmd.finish) begin
        if (next_found) begin
          cur_valid <= 1'b1;
          cur_index <= disp_idx;
          tstate[disp_idx] <= kts_pkg::ST_RUN;
        end else cur_valid <= 1'b0;
      end
    end
  end

  // semaphore memory: written only at creation, at a wait that takes its amount and at a signal
  always_ff @(posedge clk) begin
    if (cmd.exec && r_func == kts_pkg::F_CSEMA && scount < SCW'(SEMAPHORES)) begin
      slevel[SW'(scount)] <= r_amount;
      sceil[SW'(scount)]  <= r_limit;
    end
    if (cmd.exec && r_func == kts_pkg::F_WAIT && sfound && slevel[si] >= r_amount)
      slevel[si] <= slevel[si] - r_amount;
    if (cmd.exec && r_func == kts_pkg::F_SIGNAL && sfound && tcount == '0)
      slevel[si] <= (lv_sum > {1'b0, sceil[si]}) ? sceil[si] : lv_sum[15:0];
    if (cmd.sig_step && sts.scan_last) begin
      if (tstate[scan] == kts_pkg::ST_SEMA && ttarget[scan] == r_id && lv != '0)
        slevel[si] <= lv[15:0] - 16'd1;
      else slevel[si] <= lv[15:0];
    end
  end

  // request capture and scan working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_func <= func;
      r_id <= object_id;
      r_amount <= amount;
      r_limit <= limit;
      r_ticks <= wait_ticks;
      old_valid <= cur_valid;
      old_index <= cur_index;
      rc_block <= 1'b0;
      made <= '0;
    end
    if (cmd.exec) begin
      y_ticks <= (r_func == kts_pkg::F_YIELD) ? r_ticks : '0;
      rc_block <= (r_func == kts_pkg::F_SLEEP) || (r_func == kts_pkg::F_WAIT);
      old_index <= cur_index;
      lv <= (lv_sum > {1'b0, sceil[si]}) ? {1'b0, sceil[si]} : lv_sum;
      rc <= kts_pkg::RC_DONE;
      case (r_func)
        kts_pkg::F_CREATE: begin
          if (tcount >= TCW'(THREADS)) rc <= kts_pkg::RC_NOTFOUND;
          else made <= 5'(tcount) + 5'd1;
        end
        kts_pkg::F_START:
          if (!tfound || tstate[ti] != kts_pkg::ST_READY) rc <= kts_pkg::RC_NOTFOUND;
        kts_pkg::F_WAKEUP: if (!tfound) rc <= kts_pkg::RC_NOTFOUND;
        kts_pkg::F_CSEMA: begin
          if (scount >= SCW'(SEMAPHORES)) rc <= kts_pkg::RC_NOTFOUND;
          else made <= 5'(scount) + 5'd1;
        end
        kts_pkg::F_WAIT: begin
          if (!sfound) rc <= kts_pkg::RC_NOTFOUND;
          else if (slevel[si] < r_amount && !cur_valid) rc <= kts_pkg::RC_BLOCKED;
        end
        kts_pkg::F_SIGNAL: if (!sfound) rc <= kts_pkg::RC_NOTFOUND;
        kts_pkg::F_YIELD, kts_pkg::F_EXIT, kts_pkg::F_SLEEP: ;
        default: rc <= kts_pkg::RC_NOTFOUND;
      endcase
    end
    if (cmd.sig_step && tstate[scan] == kts_pkg::ST_SEMA
        && ttarget[scan] == r_id && lv != '0)
      lv <= lv - 17'd1;
    if (cmd.yprep) begin
      next_found <= 1'b0;
      any_timed <= 1'b0;
      least <= kts_pkg::DELAY_MAX;
    end
    if (cmd.rr_step && sts.rr_hit && !next_found) begin
      next_found <= 1'b1;
      disp_idx <= rr_idx;
    end
    if (cmd.min_step && tstate[scan] == kts_pkg::ST_TIMED) begin
      any_timed <= 1'b1;
      if (tdelay[scan] < least) least <= tdelay[scan];
    end
    if (cmd.adv_step && tstate[scan] == kts_pkg::ST_TIMED
        && tdelay[scan] == least && !next_found) begin
      next_found <= 1'b1;
      disp_idx <= scan;
    end
    if (cmd.finish) begin
      if (!next_found) rc <= kts_pkg::RC_DEADLOCK;
      else if (rc_block) rc <= kts_pkg::RC_BLOCKED;
    end
  end

  assign result_code   = rc;
  assign created_id    = made;
  assign running_valid = cur_valid;
  assign running_index = cur_valid ? 4'(cur_index) : 4'd0;
  assign switched = (old_valid != cur_valid) ||
                    (old_valid && cur_valid && old_index != cur_index);

endmodule

FILE: src/kts_ctrl.sv
// Controller of the kernel thread scheduler: request sequencing and the
// yield scan passes. Uses kts_pkg.
module kts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output kts_pkg::cmd_t cmd,
  input  kts_pkg::sts_t sts
);

  kts_pkg::ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= kts_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      kts_pkg::S_IDLE:   if (in_valid) state_next = kts_pkg::S_EXEC;
      kts_pkg::S_EXEC:
        if (sts.go_yield) state_next = kts_pkg::S_YPREP;
        else if (sts.go_signal) state_next = kts_pkg::S_SIGNAL;
        else state_next = kts_pkg::S_OUT;
      kts_pkg::S_SIGNAL: if (sts.scan_last) state_next = kts_pkg::S_OUT;
      kts_pkg::S_YPREP:  state_next = kts_pkg::S_RRSCAN;
      kts_pkg::S_RRSCAN:
        if (sts.rr_hit) state_next = kts_pkg::S_FINISH;
        else if (sts.scan_last) state_next = kts_pkg::S_MINSCAN;
      kts_pkg::S_MINSCAN: if (sts.scan_last) state_next = kts_pkg::S_ADVSCAN;
      kts_pkg::S_ADVSCAN:
        if (!sts.any_timed || sts.scan_last) state_next = kts_pkg::S_FINISH;
      kts_pkg::S_FINISH: state_next = kts_pkg::S_OUT;
      kts_pkg::S_OUT:    if (out_ready) state_next = kts_pkg::S_IDLE;
      default: state_next = kts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = (state == kts_pkg::S_IDLE);
    out_valid = (state == kts_pkg::S_OUT);
    case (state)
      kts_pkg::S_IDLE:    cmd.load = in_valid;
      kts_pkg::S_EXEC:    begin cmd.exec = 1'b1; cmd.scan_clr = 1'b1; end
      kts_pkg::S_SIGNAL:  cmd.sig_step = 1'b1;
      kts_pkg::S_YPREP:   begin cmd.yprep = 1'b1; cmd.scan_clr = 1'b1; end
      kts_pkg::S_RRSCAN: begin
        cmd.rr_step = 1'b1;
        if (sts.scan_last) cmd.scan_clr = 1'b1;
      end
      kts_pkg::S_MINSCAN: begin
        cmd.min_step = 1'b1;
        if (sts.scan_last) cmd.scan_clr = 1'b1;
      end
      kts_pkg::S_ADVSCAN: cmd.adv_step = sts.any_timed;
      kts_pkg::S_FINISH:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in_ready with out_valid");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_load_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == kts_pkg::S_EXEC) else $error("no exec");
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    state == kts_pkg::S_FINISH |=> out_valid) else $error("finish lost");

endmodule

FILE: src/kernel_thread_scheduler.sv
// Kernel thread scheduler: round robin dispatch with tick delays, sleep and
// wakeup credits, and counted semaphores. One request in, one result out.
// Simple requests are captured, executed and then present their result; a
// signal adds a scan step per created thread; a yield (also exit, blocking
// sleep or wait) adds the caller update, the round robin, least delay and
// timer advance passes over the thread table (one thread per cycle) and the
// dispatch commit. A new request is accepted no earlier than the cycle after
// the previous result has been taken, so requests never overlap. Uses
// kts_pkg.
module kernel_thread_scheduler #(
  parameter int THREADS = 16,
  parameter int SEMAPHORES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  func,
  input  logic [7:0]  object_id,
  input  logic [15:0] amount,
  input  logic [15:0] limit,
  input  logic [31:0] wait_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  result_code,
  output logic [4:0]  created_id,
  output logic        switched,
  output logic        running_valid,
  output logic [3:0]  running_index
);

  kts_pkg::cmd_t cmd;
  kts_pkg::sts_t sts;

  kts_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
  );

  kts_datapath #(.THREADS(THREADS), .SEMAPHORES(SEMAPHORES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .func(func), .object_id(object_id), .amount(amount), .limit(limit),
    .wait_ticks(wait_ticks), .result_code(result_code),
    .created_id(created_id), .switched(switched),
    .running_valid(running_valid), .running_index(running_index)
  );

endmodule
